/* hw/rtl/mss_pkg.sv */
`default_nettype none
package mss_pkg;

	localparam int HISTORY_WORDS     = 32;
	localparam int MAX_PATTERN_WORDS = 6;
	localparam int MAX_OFFSETS       = 4;

	localparam int WORD_W     = 32;
	localparam int ADDR_W     = 48;
	localparam int COUNT_W    = 8;
	localparam int STATUS_W   = 2;
	localparam int REGION_W   = 6;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int PW_W       = 3;
	localparam int PWE_W      = 4;
	localparam int OFFS_W     = 24;
	localparam int OFF_W      = 5;
	localparam int OFF_EN_LSB = 20;
	localparam int BACK_W     = 7;
	localparam int PAT_WORDS  = 6;
	localparam int BANK_W     = 3 * CFG_W;
	localparam int LANES      = 4;
	localparam int NCNT_W     = 3;

	localparam logic [REGION_W-1:0] REGION_MAX = 6'd63;
	localparam logic [COUNT_W-1:0]  COUNT_MAX  = 8'd255;
	localparam logic [PW_W-1:0]     PW_RESET   = 3'd5;

	localparam logic [WORD_W-1:0] PROLOGUE_MASK  = {8'hff, 8'hc0, 8'h7f, 8'hff};
	localparam logic [WORD_W-1:0] PROLOGUE_VALUE = {8'ha9, 8'h80, 8'h7b, 8'hfd};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LO   = 3'd0,
		CFG_PATTERN_MID  = 3'd1,
		CFG_PATTERN_HI   = 3'd2,
		CFG_MASK_LO      = 3'd3,
		CFG_MASK_MID     = 3'd4,
		CFG_MASK_HI      = 3'd5,
		CFG_PATTERN_WORDS = 3'd6,
		CFG_BACK_OFFSETS = 3'd7
	} cfg_idx_t;

	localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_ONE     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SEVERAL = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [ADDR_W-1:0] word_addr;
		logic              region_first;
		logic              scan_last;
	} in_beat_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   found_addr;
		logic [COUNT_W-1:0]  match_count;
		logic [STATUS_W-1:0] scan_status;
	} out_beat_t;

	typedef struct packed {
		logic                valid;
		logic                last;
		logic [REGION_W-1:0] region_count;
	} s1_t;

	typedef struct packed {
		logic                         valid;
		logic                         last;
		logic [LANES-1:0]             acc;
		logic [LANES-1:0][ADDR_W-1:0] addr;
	} s2_t;

	// word k of a 192-bit pattern or mask bank; words past the bank are zero
	function automatic logic [WORD_W-1:0] bank_word(input logic [BANK_W-1:0] bank, input int k);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < PAT_WORDS; i++) begin
			if (i == k) w = bank[WORD_W*i +: WORD_W];
		end
		return w;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/mss_stream_if.sv */
`default_nettype none
interface mss_stream_if #(parameter type beat_t = logic);
	logic  valid;
	logic  ready;
	beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mss_cell.sv */
`default_nettype none
module mss_cell (
	input  wire logic                       clk,
	input  wire logic                       shift,
	input  wire logic [mss_pkg::WORD_W-1:0] d_word,
	input  wire logic [mss_pkg::ADDR_W-1:0] d_addr,
	output logic      [mss_pkg::WORD_W-1:0] q_word,
	output logic      [mss_pkg::ADDR_W-1:0] q_addr,
	output logic                            prologue
);

	logic [mss_pkg::WORD_W-1:0] word_q;
	logic [mss_pkg::ADDR_W-1:0] addr_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d_word;
			addr_q <= d_addr;
		end
	end

	assign q_word   = word_q;
	assign q_addr   = addr_q;
	assign prologue = (word_q & mss_pkg::PROLOGUE_MASK) == mss_pkg::PROLOGUE_VALUE;

endmodule
`default_nettype wire

/* hw/rtl/mss_match.sv */
`default_nettype none
module mss_match #(
	parameter int HISTORY_WORDS     = mss_pkg::HISTORY_WORDS,
	parameter int MAX_PATTERN_WORDS = mss_pkg::MAX_PATTERN_WORDS,
	parameter int MAX_OFFSETS       = mss_pkg::MAX_OFFSETS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [mss_pkg::WORD_W-1:0]  cell_word [HISTORY_WORDS],
	input  wire logic [mss_pkg::ADDR_W-1:0]  cell_addr [HISTORY_WORDS],
	input  wire logic [HISTORY_WORDS-1:0]    cell_pro,
	input  wire mss_pkg::s1_t                s1,
	input  wire logic [mss_pkg::BANK_W-1:0]  pattern,
	input  wire logic [mss_pkg::BANK_W-1:0]  mask,
	input  wire logic [mss_pkg::PW_W-1:0]    pattern_words,
	input  wire logic [mss_pkg::OFFS_W-1:0]  back_offsets,
	output mss_pkg::s2_t                     s2
);

	localparam int IDX_W = $clog2(HISTORY_WORDS);
	localparam int PWE_W = mss_pkg::PWE_W;
	localparam int BACK_W = mss_pkg::BACK_W;

	logic [PWE_W-1:0]           pw_eff;
	logic                       hit;
	logic [mss_pkg::WORD_W-1:0] win;
	logic [PWE_W-1:0]           sel;
	logic [BACK_W-1:0]          back [mss_pkg::LANES];
	logic [mss_pkg::LANES-1:0]  cand_ok;
	logic [mss_pkg::LANES-1:0][mss_pkg::ADDR_W-1:0] cand_addr;
	mss_pkg::s2_t               s2_s2;

	always_comb begin
		pw_eff = PWE_W'(pattern_words);
		if (pattern_words == '0) pw_eff = PWE_W'(1);
		if (pw_eff > PWE_W'(MAX_PATTERN_WORDS)) pw_eff = PWE_W'(MAX_PATTERN_WORDS);
	end

	// pattern word k sits pw_eff-1-k cells behind the newest word
	always_comb begin
		hit = s1.valid && (mss_pkg::REGION_W'(pw_eff) <= s1.region_count);
		win = '0;
		sel = '0;
		for (int k = 0; k < MAX_PATTERN_WORDS; k++) begin
			win = '0;
			sel = pw_eff - PWE_W'(k + 1);
			for (int j = 0; j < MAX_PATTERN_WORDS; j++) begin
				if (PWE_W'(j) == sel) win = cell_word[j];
			end
			if (PWE_W'(k) < pw_eff &&
			    ((win ^ mss_pkg::bank_word(pattern, k)) & mss_pkg::bank_word(mask, k)) != '0)
				hit = 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < mss_pkg::LANES; i++) begin
			back[i] = BACK_W'(pw_eff) - BACK_W'(1)
			        + BACK_W'(back_offsets[mss_pkg::OFF_W*i +: mss_pkg::OFF_W]);
			cand_ok[i] = (i < MAX_OFFSETS) && back_offsets[mss_pkg::OFF_EN_LSB + i]
			          && (back[i] < BACK_W'(s1.region_count))
			          && (back[i] < BACK_W'(HISTORY_WORDS))
			          && cell_pro[back[i][IDX_W-1:0]];
			cand_addr[i] = cell_addr[back[i][IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_s2 <= '0;
		end else if (advance) begin
			s2_s2.valid <= s1.valid;
			s2_s2.last  <= s1.last;
			s2_s2.acc   <= cand_ok & {mss_pkg::LANES{hit}};
			s2_s2.addr  <= cand_addr;
		end
	end

	assign s2 = s2_s2;

endmodule
`default_nettype wire

/* hw/rtl/mss_tally.sv */
`default_nettype none
module mss_tally (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mss_pkg::s2_t  s2,
	mss_stream_if.source       result,
	output logic               advance
);

	localparam int COUNT_W = mss_pkg::COUNT_W;

	logic [COUNT_W-1:0]         count_q;
	logic [mss_pkg::ADDR_W-1:0] first_q;
	logic                       out_valid_q;
	mss_pkg::out_beat_t         out_q;

	logic [mss_pkg::NCNT_W-1:0] n_acc;
	logic [COUNT_W:0]           sum;
	logic [COUNT_W-1:0]         count_nx;
	logic [mss_pkg::ADDR_W-1:0] first_nx;
	logic                       emit;
	mss_pkg::out_beat_t         report;

	// hold the pipe only when a scan end meets a result still waiting
	assign advance = !(s2.valid && s2.last && out_valid_q && !result.ready);
	assign emit    = advance && s2.valid && s2.last;

	always_comb begin
		n_acc    = mss_pkg::NCNT_W'($countones(s2.acc));
		sum      = {1'b0, count_q} + (COUNT_W+1)'(n_acc);
		count_nx = (sum > (COUNT_W+1)'(mss_pkg::COUNT_MAX)) ? mss_pkg::COUNT_MAX : sum[COUNT_W-1:0];
		first_nx = first_q;
		if (count_q == '0) begin
			// lowest accepting lane comes first
			for (int i = mss_pkg::LANES - 1; i >= 0; i--) begin
				if (s2.acc[i]) first_nx = s2.addr[i];
			end
		end
		report.match_count = count_nx;
		report.found_addr  = (count_nx != '0) ? first_nx : '0;
		case (count_nx)
			COUNT_W'(0): report.scan_status = mss_pkg::STATUS_NONE;
			COUNT_W'(1): report.scan_status = mss_pkg::STATUS_ONE;
			default:     report.scan_status = mss_pkg::STATUS_SEVERAL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			first_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && s2.valid) begin
				if (s2.last) begin
					count_q <= '0;
					first_q <= '0;
				end else begin
					count_q <= count_nx;
					first_q <= first_nx;
				end
			end
			if (emit) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= report;
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	a_clear_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (count_q == '0) && (first_q == '0))
		else $error("count not cleared after scan end");

	a_status_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_q.scan_status == mss_pkg::STATUS_ONE) == (out_q.match_count == COUNT_W'(1))))
		else $error("status disagrees with count");

	a_none_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.scan_status == mss_pkg::STATUS_NONE) |-> (out_q.found_addr == '0))
		else $error("address reported without a candidate");

endmodule
`default_nettype wire

/* hw/rtl/masked_signature_scanner_top.sv */
// Masked signature scanner. Streams 32-bit words with their addresses through a row of
// HISTORY_WORDS cells; each cell holds one recent word and flags a frame prologue. The newest
// pattern_words cells are compared bit by bit with the masked pattern, and each enabled back
// offset checks one older cell of the current region. One word is taken every cycle while
// input is ready; a result passes the s1 and s2 registers into the output. Input ready drops
// only while a result waits at the output and the next scan end has reached the counter.
`default_nettype none
module masked_signature_scanner_top #(
	parameter int HISTORY_WORDS     = mss_pkg::HISTORY_WORDS,
	parameter int MAX_PATTERN_WORDS = mss_pkg::MAX_PATTERN_WORDS,
	parameter int MAX_OFFSETS       = mss_pkg::MAX_OFFSETS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [mss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [mss_pkg::CFG_W-1:0]       cfg_wdata,
	mss_stream_if.sink                           words,
	mss_stream_if.source                         result
);

	localparam int CFG_W    = mss_pkg::CFG_W;
	localparam int REGION_W = mss_pkg::REGION_W;

	logic [CFG_W-1:0]            pat_q [3];
	logic [CFG_W-1:0]            msk_q [3];
	logic [mss_pkg::PW_W-1:0]    pw_q;
	logic [mss_pkg::OFFS_W-1:0]  boff_q;

	logic                        advance;
	logic                        accept;
	logic [REGION_W-1:0]         region_q;
	logic [REGION_W-1:0]         region_base;
	logic [REGION_W-1:0]         region_nx;
	mss_pkg::s1_t                s1_s1;
	mss_pkg::s2_t                s2;
	mss_pkg::in_beat_t           beat;

	logic [mss_pkg::WORD_W-1:0]  cell_word [HISTORY_WORDS];
	logic [mss_pkg::ADDR_W-1:0]  cell_addr [HISTORY_WORDS];
	logic [HISTORY_WORDS-1:0]    cell_pro;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pat_q[i] <= '0;
				msk_q[i] <= '0;
			end
			pw_q   <= mss_pkg::PW_RESET;
			boff_q <= '0;
		end else if (cfg_wr_en) begin
			case (mss_pkg::cfg_idx_t'(cfg_index))
				mss_pkg::CFG_PATTERN_LO:    pat_q[0] <= cfg_wdata;
				mss_pkg::CFG_PATTERN_MID:   pat_q[1] <= cfg_wdata;
				mss_pkg::CFG_PATTERN_HI:    pat_q[2] <= cfg_wdata;
				mss_pkg::CFG_MASK_LO:       msk_q[0] <= cfg_wdata;
				mss_pkg::CFG_MASK_MID:      msk_q[1] <= cfg_wdata;
				mss_pkg::CFG_MASK_HI:       msk_q[2] <= cfg_wdata;
				mss_pkg::CFG_PATTERN_WORDS: pw_q     <= cfg_wdata[mss_pkg::PW_W-1:0];
				mss_pkg::CFG_BACK_OFFSETS:  boff_q   <= cfg_wdata[mss_pkg::OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	assign beat         = words.data;
	assign accept       = words.valid && advance;
	assign words.ready  = advance;

	// region length counts the new word and saturates
	assign region_base = beat.region_first ? '0 : region_q;
	assign region_nx   = (region_base == mss_pkg::REGION_MAX) ? mss_pkg::REGION_MAX
	                   : region_base + REGION_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
			s1_s1    <= '0;
		end else if (advance) begin
			if (accept) region_q <= beat.scan_last ? '0 : region_nx;
			s1_s1.valid        <= accept;
			s1_s1.last         <= beat.scan_last;
			s1_s1.region_count <= region_nx;
		end
	end

	for (genvar j = 0; j < HISTORY_WORDS; j++) begin : g_cell
		logic [mss_pkg::WORD_W-1:0] d_word;
		logic [mss_pkg::ADDR_W-1:0] d_addr;
		if (j == 0) begin : g_head
			assign d_word = beat.word;
			assign d_addr = beat.word_addr;
		end else begin : g_link
			assign d_word = cell_word[j-1];
			assign d_addr = cell_addr[j-1];
		end
		mss_cell u_cell (
			.clk      (clk),
			.shift    (accept),
			.d_word   (d_word),
			.d_addr   (d_addr),
			.q_word   (cell_word[j]),
			.q_addr   (cell_addr[j]),
			.prologue (cell_pro[j])
		);
	end

	mss_match #(
		.HISTORY_WORDS     (HISTORY_WORDS),
		.MAX_PATTERN_WORDS (MAX_PATTERN_WORDS),
		.MAX_OFFSETS       (MAX_OFFSETS)
	) u_match (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.cell_word     (cell_word),
		.cell_addr     (cell_addr),
		.cell_pro      (cell_pro),
		.s1            (s1_s1),
		.pattern       ({pat_q[2], pat_q[1], pat_q[0]}),
		.mask          ({msk_q[2], msk_q[1], msk_q[0]}),
		.pattern_words (pw_q),
		.back_offsets  (boff_q),
		.s2            (s2)
	);

	mss_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.s2      (s2),
		.result  (result),
		.advance (advance)
	);

	a_stall_only_on_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!words.ready |-> (result.valid && !result.ready && s2.valid && s2.last))
		else $error("input stalled without a waiting result");

endmodule
`default_nettype wire
